FILE: rtl/mep_pkg.sv
package mep_pkg;

	localparam int CRD_W = 48;
	localparam int SIDE_W = 47;
	localparam int ITER_W = 12;
	localparam int PIX_W = 10;
	localparam int PHASE_W = 7;
	localparam int Z_W = 64;
	localparam int FRAC_W = 44;
	localparam int MAG_W = 56;
	localparam int DEF_IMAGE_WIDTH = 1024;
	localparam int DEF_IMAGE_HEIGHT = 768;
	localparam int PHASE_PERIOD = 100;

	localparam logic [1:0] REG_CENTER_RE = 2'd0;
	localparam logic [1:0] REG_CENTER_IM = 2'd1;
	localparam logic [1:0] REG_VIEW_SIDE = 2'd2;
	localparam logic [1:0] REG_MAX_ITER = 2'd3;

	localparam logic signed [Z_W-1:0] Q_QUARTER = 64'sd1 <<< 42;
	localparam logic signed [Z_W-1:0] Q_ONE = 64'sd1 <<< 44;
	localparam logic signed [Z_W-1:0] Q_SIXTEENTH = 64'sd1 <<< 40;
	localparam logic signed [Z_W-1:0] Q_FOUR = 64'sd1 <<< 46;
	localparam logic signed [Z_W-1:0] Q_MAX = 64'sd140737488355327;
	localparam logic signed [Z_W-1:0] Q_MIN = -64'sd140737488355328;

	typedef logic [PHASE_W-1:0] phase_t;

	function automatic logic [7:0] red_lut(input phase_t p);
		logic [7:0] t [0:99];
		t = '{8'd127, 8'd134, 8'd142, 8'd150, 8'd158, 8'd166, 8'd173, 8'd181, 8'd188,
			8'd195, 8'd201, 8'd207, 8'd213, 8'd219, 8'd224, 8'd229, 8'd234, 8'd238,
			8'd241, 8'd245, 8'd247, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253, 8'd253,
			8'd252, 8'd251, 8'd250, 8'd247, 8'd245, 8'd241, 8'd238, 8'd234, 8'd229,
			8'd224, 8'd219, 8'd213, 8'd207, 8'd201, 8'd195, 8'd188, 8'd181, 8'd173,
			8'd166, 8'd158, 8'd150, 8'd142, 8'd134, 8'd126, 8'd119, 8'd111, 8'd103,
			8'd95, 8'd87, 8'd80, 8'd72, 8'd65, 8'd58, 8'd52, 8'd46, 8'd40, 8'd34,
			8'd29, 8'd24, 8'd19, 8'd15, 8'd12, 8'd8, 8'd6, 8'd3, 8'd2, 8'd1, 8'd0,
			8'd0, 8'd0, 8'd1, 8'd2, 8'd3, 8'd6, 8'd8, 8'd12, 8'd15, 8'd19, 8'd24,
			8'd29, 8'd34, 8'd40, 8'd46, 8'd52, 8'd58, 8'd65, 8'd72, 8'd80, 8'd87,
			8'd95, 8'd103, 8'd111, 8'd119};
		if (p < 7'd100)
			return t[p];
		return 8'd0;
	endfunction

endpackage

FILE: rtl/mep_mul_cell.sv
module mep_mul_cell
	import mep_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAG_W-1:0]     a,
	input  logic [MAG_W-1:0]     b,
	input  logic                 neg,
	output logic                 done,
	output logic signed [Z_W-1:0] prod
);

	// 4 partial products of 28x28, one per cycle, accumulated
	localparam int H = MAG_W / 2;

	logic [MAG_W-1:0] a_q, b_q;
	logic neg_q;
	logic [2:0] step_q;
	logic busy_q;
	logic [2*MAG_W-1:0] acc_q;
	logic [H-1:0] pa, pb;
	logic [2*H-1:0] pp;
	logic [2*MAG_W-1:0] pp_sh;
	logic [Z_W-1:0] mag;

	always_comb begin
		pa = step_q[1] ? a_q[MAG_W-1:H] : a_q[H-1:0];
		pb = step_q[0] ? b_q[MAG_W-1:H] : b_q[H-1:0];
		pp = pa * pb;
		pp_sh = {{(2*MAG_W-2*H){1'b0}}, pp} << (H * (32'(step_q[1]) + 32'(step_q[0])));
		mag = {2'b00, acc_q[FRAC_W +: Z_W-2]};
		prod = neg_q ? -$signed(mag) : $signed(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			neg_q <= neg;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

endmodule

FILE: rtl/mep_sq_row.sv
module mep_sq_row
	import mep_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [Z_W-1:0] a0,
	input  logic signed [Z_W-1:0] b0,
	input  logic signed [Z_W-1:0] a1,
	input  logic signed [Z_W-1:0] b1,
	input  logic signed [Z_W-1:0] a2,
	input  logic signed [Z_W-1:0] b2,
	output logic                  done,
	output logic signed [Z_W-1:0] p0,
	output logic signed [Z_W-1:0] p1,
	output logic signed [Z_W-1:0] p2
);

	logic d0, d1, d2;

	function automatic logic [MAG_W-1:0] magn(input logic signed [Z_W-1:0] v);
		logic [Z_W-1:0] m;
		m = v[Z_W-1] ? 64'(-v) : 64'(v);
		return m[MAG_W-1:0];
	endfunction

	mep_mul_cell u_c0 (.clk, .arst_n, .start, .a(magn(a0)), .b(magn(b0)),
		.neg(a0[Z_W-1] ^ b0[Z_W-1]), .done(d0), .prod(p0));
	mep_mul_cell u_c1 (.clk, .arst_n, .start, .a(magn(a1)), .b(magn(b1)),
		.neg(a1[Z_W-1] ^ b1[Z_W-1]), .done(d1), .prod(p1));
	mep_mul_cell u_c2 (.clk, .arst_n, .start, .a(magn(a2)), .b(magn(b2)),
		.neg(a2[Z_W-1] ^ b2[Z_W-1]), .done(d2), .prod(p2));

	assign done = d0 & d1 & d2;

endmodule

FILE: rtl/mandelbrot_escape_pixel_unit.sv
// channel | signals                          | direction
// in      | in_valid, in_stall, pixel_x/y    | toward block
// out     | out_valid, out_stall, result set | from block
// cfg     | cfg_we, cfg_index, cfg_data      | toward block
// One pixel at a time. Mapping accumulates six 32x32 reciprocal partial
// products; each product set is computed in the row of three multiplier
// cells. Mapping and the shape tests come first, then the iterations, and
// a final state to finish.
// Reset clears control and loads register defaults. A result waits in the
// output register while out_stall is high; no new pixel is taken while it waits.
module mandelbrot_escape_pixel_unit
	import mep_pkg::*;
#(
	parameter int IMAGE_WIDTH = DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CRD_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [PIX_W-1:0]    pixel_x,
	input  logic [PIX_W-1:0]    pixel_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                inside_res,
	output logic [ITER_W-1:0]   escape_count,
	output logic [PHASE_W-1:0]  color_phase,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic [7:0]          alpha
);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_MAP = 4'd1, ST_DIV = 4'd2,
		ST_SAT = 4'd3, ST_SQ1 = 4'd4, ST_SQ2 = 4'd5, ST_TEST = 4'd6,
		ST_IT = 4'd7, ST_ITW = 4'd8, ST_DONE = 4'd9, ST_FIX = 4'd10;
	localparam int DVS = 2 * IMAGE_WIDTH;
	localparam int RCP_SH = 73;
	localparam logic [95:0] RECIP =
		96'(((128'd1 << RCP_SH) + 128'(DVS) - 128'd1) / 128'(DVS));

	logic signed [CRD_W-1:0] center_re_q, center_im_q;
	logic [SIDE_W-1:0] side_q;
	logic [ITER_W-1:0] max_it_q;
	logic [3:0] st_q;
	logic [Z_W-1:0] nre_q, nim_q;
	logic [127:0] are_q, aim_q;
	logic nsel_q;
	logic [1:0] msel_q;
	logic sre_q, sim_q;
	logic signed [Z_W-1:0] re_q, im_q, x_q, y_q, im2_q, dx_q, q_q;
	logic [ITER_W-1:0] it_q;
	phase_t ph_q, cph_q;
	logic sq_start;
	logic signed [Z_W-1:0] a0, b0, a1, b1, a2, b2, p0, p1, p2;
	logic sq_done;
	logic [31:0] ml, nl_re, nl_im;
	logic [63:0] pp_re, pp_im;
	logic [1:0] lsum;
	logic [127:0] ppx_re, ppx_im;
	logic [Z_W+1:0] qre, qim;
	logic signed [Z_W+1:0] nre_s, nim_s;
	logic signed [Z_W-1:0] nx, ny;
	logic fin_in, esc;

	mep_sq_row u_row (.clk, .arst_n, .start(sq_start), .a0, .b0, .a1, .b1, .a2, .b2,
		.done(sq_done), .p0, .p1, .p2);

	function automatic logic [Z_W:0] numer(input logic [PIX_W-1:0] pos,
		input int ext, input logic [SIDE_W-1:0] side);
		logic signed [PIX_W+13:0] d;
		logic [PIX_W+13:0] m;
		logic neg;
		d = $signed({13'd0, pos, 1'b1}) - (PIX_W+14)'(ext);
		neg = d[PIX_W+13] && (side != '0);
		m = d[PIX_W+13] ? (PIX_W+14)'(-d) : (PIX_W+14)'(d);
		return {neg, Z_W'(m) * Z_W'(side)};
	endfunction

	always_comb begin
		unique case (msel_q)
			2'd0: ml = RECIP[31:0];
			2'd1: ml = RECIP[63:32];
			default: ml = RECIP[95:64];
		endcase
		nl_re = nsel_q ? nre_q[63:32] : nre_q[31:0];
		nl_im = nsel_q ? nim_q[63:32] : nim_q[31:0];
		pp_re = {32'd0, nl_re} * {32'd0, ml};
		pp_im = {32'd0, nl_im} * {32'd0, ml};
		lsum = msel_q + {1'b0, nsel_q};
		ppx_re = {64'd0, pp_re} << {lsum, 5'd0};
		ppx_im = {64'd0, pp_im} << {lsum, 5'd0};
		qre = (Z_W+2)'(are_q[127:RCP_SH]);
		qim = (Z_W+2)'(aim_q[127:RCP_SH]);
		nre_s = $signed({{(Z_W+2-CRD_W){center_re_q[CRD_W-1]}}, center_re_q}) +
			(sre_q ? -$signed(qre) : $signed(qre));
		nim_s = $signed({{(Z_W+2-CRD_W){center_im_q[CRD_W-1]}}, center_im_q}) +
			(sim_q ? -$signed(qim) : $signed(qim));
	end

	always_comb begin
		sq_start = 1'b0;
		a0 = x_q; b0 = x_q; a1 = y_q; b1 = y_q; a2 = x_q; b2 = y_q;
		unique case (st_q)
			ST_SAT: begin
				sq_start = 1'b1;
				a0 = im_q; b0 = im_q;
				a1 = re_q - Q_QUARTER; b1 = re_q - Q_QUARTER;
				a2 = re_q + Q_ONE; b2 = re_q + Q_ONE;
			end
			ST_SQ2: begin
				sq_start = 1'b1;
				a0 = q_q; b0 = q_q + dx_q;
				a1 = re_q + Q_ONE; b1 = re_q + Q_ONE;
			end
			ST_IT: sq_start = 1'b1;
			default: ;
		endcase
		esc = (p0 + p1) > Q_FOUR;
		nx = p0 - p1 + re_q;
		ny = (p2 <<< 1) + im_q;
		fin_in = (p0 <= (im2_q >>> 2)) || ((p1 + im2_q) <= Q_SIXTEENTH);
	end

	assign in_stall = (st_q != ST_IDLE) || (out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q <= '0;
			center_im_q <= '0;
			side_q <= SIDE_W'(64'd1 << 46);
			max_it_q <= ITER_W'(1000);
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CENTER_RE: center_re_q <= cfg_data;
					REG_CENTER_IM: center_im_q <= cfg_data;
					REG_VIEW_SIDE: side_q <= cfg_data[SIDE_W-1:0];
					REG_MAX_ITER: max_it_q <= cfg_data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid && !in_stall) st_q <= ST_MAP;
				ST_MAP: st_q <= ST_DIV;
				ST_DIV: if (nsel_q && msel_q == 2'd2) st_q <= ST_FIX;
				ST_FIX: st_q <= ST_SAT;
				ST_SAT: st_q <= ST_SQ1;
				ST_SQ1: if (sq_done) st_q <= ST_SQ2;
				ST_SQ2: st_q <= ST_TEST;
				ST_TEST: if (sq_done) st_q <= fin_in ? ST_DONE :
					(max_it_q == '0 ? ST_DONE : ST_IT);
				ST_IT: st_q <= ST_ITW;
				ST_ITW: if (sq_done) begin
					if (esc || (nx == x_q && ny == y_q) || it_q + 1'b1 == max_it_q)
						st_q <= ST_DONE;
					else
						st_q <= ST_IT;
				end
				ST_DONE: if (!out_valid || !out_stall) begin
					st_q <= ST_IDLE;
					out_valid <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				{sre_q, nre_q} <= numer(pixel_x, IMAGE_WIDTH, side_q);
				{sim_q, nim_q} <= numer(pixel_y, IMAGE_HEIGHT, side_q);
			end
			ST_MAP: begin
				are_q <= '0; aim_q <= '0;
				nsel_q <= 1'b0; msel_q <= '0;
				inside_res <= 1'b1;
				escape_count <= '0;
				cph_q <= '0;
			end
			ST_DIV: begin
				are_q <= are_q + ppx_re;
				aim_q <= aim_q + ppx_im;
				if (msel_q == 2'd2) begin
					msel_q <= '0;
					nsel_q <= 1'b1;
				end else begin
					msel_q <= msel_q + 2'd1;
				end
			end
			ST_FIX: begin
				re_q <= nre_s > Q_MAX ? Q_MAX : (nre_s < Q_MIN ? Q_MIN : Z_W'(nre_s));
				im_q <= nim_s > Q_MAX ? Q_MAX : (nim_s < Q_MIN ? Q_MIN : Z_W'(nim_s));
			end
			ST_SAT: begin
				dx_q <= re_q - Q_QUARTER;
				x_q <= '0; y_q <= '0; it_q <= '0;
				ph_q <= '0;
			end
			ST_SQ1: if (sq_done) begin
				im2_q <= p0;
				q_q <= p1 + p0;
			end
			ST_ITW: if (sq_done) begin
				if (esc) begin
					inside_res <= 1'b0;
					escape_count <= it_q;
					cph_q <= ph_q;
				end
				x_q <= nx; y_q <= ny;
				it_q <= it_q + 1'b1;
				ph_q <= (ph_q == PHASE_W'(PHASE_PERIOD - 1)) ? '0 : ph_q + 7'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		color_phase = inside_res ? '0 : cph_q;
		red = inside_res ? 8'd0 : red_lut(cph_q);
		green = inside_res ? 8'd0 : 8'd100;
		blue = green;
		alpha = 8'd255;
	end

endmodule

FILE: verif/mep_checker.sv
`timescale 1ns / 100ps

module mep_checker
	import mep_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CRD_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [PIX_W-1:0]   pixel_x,
	input  logic [PIX_W-1:0]   pixel_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               inside_res,
	input  logic [ITER_W-1:0]  escape_count,
	input  logic [PHASE_W-1:0] color_phase,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [7:0]         alpha,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic               in_set;
		logic [ITER_W-1:0]  count;
		logic [PHASE_W-1:0] phase;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic [7:0]         a;
	} pixel_color_t;

	localparam logic [7:0] SINE_RED [0:99] = '{
		127, 134, 142, 150, 158, 166, 173, 181, 188, 195, 201, 207, 213, 219, 224,
		229, 234, 238, 241, 245, 247, 250, 251, 252, 253,
		253, 253, 252, 251, 250, 247, 245, 241, 238, 234, 229, 224, 219, 213, 207,
		201, 195, 188, 181, 173, 166, 158, 150, 142, 134,
		126, 119, 111, 103, 95, 87, 80, 72, 65, 58, 52, 46, 40, 34, 29,
		24, 19, 15, 12, 8, 6, 3, 2, 1, 0,
		0, 0, 1, 2, 3, 6, 8, 12, 15, 19, 24, 29, 34, 40, 46,
		52, 58, 65, 72, 80, 87, 95, 103, 111, 119};

	longint view_re;
	longint view_im;
	longint side;
	int     iter_limit;
	pixel_color_t color_q [$];

	function automatic longint qmul(longint a, longint b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] p;
		logic [63:0] m;
		logic neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		m = p[107:44];
		m[63:62] = 2'b00;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint map_axis(longint ctr, int pos, int extent);
		longint num;
		longint v;
		num = (longint'(2 * pos + 1) - longint'(extent)) * side;
		v = ctr + num / (2 * DEF_IMAGE_WIDTH);
		if (v > Q_MAX)
			v = Q_MAX;
		if (v < Q_MIN)
			v = Q_MIN;
		return v;
	endfunction

	function automatic pixel_color_t shade_pixel(int px, int py);
		pixel_color_t c;
		longint re, im, im2, dx, q, bx, x, y, x2, y2, nx, ny;
		logic ins;
		int cnt;
		int ph;
		re = map_axis(view_re, px, DEF_IMAGE_WIDTH);
		im = map_axis(view_im, py, DEF_IMAGE_HEIGHT);
		ins = 1'b1;
		cnt = 0;
		im2 = qmul(im, im);
		dx = re - Q_QUARTER;
		q = qmul(dx, dx) + im2;
		bx = re + Q_ONE;
		if (!(qmul(q, q + dx) <= (im2 >>> 2) || qmul(bx, bx) + im2 <= Q_SIXTEENTH)) begin
			x = 0;
			y = 0;
			for (int i = 0; i < iter_limit; i++) begin
				x2 = qmul(x, x);
				y2 = qmul(y, y);
				if (x2 + y2 > Q_FOUR) begin
					ins = 1'b0;
					cnt = i;
					break;
				end
				nx = x2 - y2 + re;
				ny = 2 * qmul(x, y) + im;
				if (nx == x && ny == y)
					break;
				x = nx;
				y = ny;
			end
		end
		c.a = 8'd255;
		if (ins) begin
			c.in_set = 1'b1;
			c.count = '0;
			c.phase = '0;
			c.r = 8'd0;
			c.g = 8'd0;
			c.b = 8'd0;
		end else begin
			ph = cnt % PHASE_PERIOD;
			c.in_set = 1'b0;
			c.count = cnt[ITER_W-1:0];
			c.phase = ph[PHASE_W-1:0];
			c.r = SINE_RED[ph];
			c.g = 8'd100;
			c.b = 8'd100;
		end
		return c;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_color_t want;
		if (!arst_n) begin
			view_re = 0;
			view_im = 0;
			side = longint'(1) << 46;
			iter_limit = 1000;
			color_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CENTER_RE: view_re = longint'($signed(cfg_data));
					REG_CENTER_IM: view_im = longint'($signed(cfg_data));
					REG_VIEW_SIDE: side = longint'({17'd0, cfg_data[SIDE_W-1:0]});
					REG_MAX_ITER: iter_limit = int'(cfg_data[ITER_W-1:0]);
				endcase
			end
			if (out_valid && !out_stall) begin
				if (color_q.size() == 0) begin
					report("unexpected result word", 1, 0);
				end else begin
					want = color_q.pop_front();
					if (inside_res !== want.in_set)
						report("inside_res", inside_res, want.in_set);
					if (escape_count !== want.count)
						report("escape_count", escape_count, want.count);
					if (color_phase !== want.phase)
						report("color_phase", color_phase, want.phase);
					if (red !== want.r)
						report("red", red, want.r);
					if (green !== want.g)
						report("green", green, want.g);
					if (blue !== want.b)
						report("blue", blue, want.b);
					if (alpha !== want.a)
						report("alpha", alpha, want.a);
				end
			end
			if (in_valid && !in_stall)
				color_q.push_back(shade_pixel(int'(pixel_x), int'(pixel_y)));
			pending <= color_q.size();
		end
	end

endmodule

FILE: verif/tb_mandelbrot_escape_pixel_unit.sv
`timescale 1ns / 100ps

module tb_mandelbrot_escape_pixel_unit
	import mep_pkg::*;
();

	localparam int CYCLE_LIMIT = 3000000;
	localparam longint Q1 = longint'(1) << 44;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [CRD_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               inside_res;
	logic [ITER_W-1:0]  escape_count;
	logic [PHASE_W-1:0] color_phase;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [7:0]         alpha;
	int                 fail_count;
	int                 pending;

	int  idle_pct;
	int  stall_pct;
	logic hold_trig;
	int  hold_left = 0;
	logic hold_done = 1'b0;
	int  cycles = 0;

	mandelbrot_escape_pixel_unit uut (.*);

	mep_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[mandelbrot_escape_pixel_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_trig && !hold_done && hold_left == 0) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_reg(logic [1:0] idx, longint val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CRD_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(int x, int y);
		in_valid <= 1'b1;
		pixel_x <= x[PIX_W-1:0];
		pixel_y <= y[PIX_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic longint milli_q(int v);
		return (longint'(v) * Q1) / 1000;
	endfunction

	initial begin
		longint rnd;
		idle_pct = 0;
		stall_pct = 0;
		hold_trig = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CENTER_RE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pixel_x <= '0;
		pixel_y <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(0, 0);
		send_pixel(1023, 767);
		send_pixel(1023, 1023);
		send_pixel(512, 384);
		send_pixel(0, 384);
		send_pixel(128, 384);
		send_pixel(1000, 100);
		send_pixel(700, 300);
		drain();

		write_reg(REG_MAX_ITER, 0);
		send_pixel(0, 0);
		send_pixel(600, 200);
		drain();
		write_reg(REG_MAX_ITER, 1);
		send_pixel(0, 0);
		send_pixel(900, 700);
		drain();
		write_reg(REG_VIEW_SIDE, 0);
		write_reg(REG_CENTER_RE, 64'h7FFFFFFFFFFF);
		write_reg(REG_CENTER_IM, 64'hFFFF800000000000);
		write_reg(REG_MAX_ITER, 4095);
		send_pixel(5, 5);
		drain();
		write_reg(REG_CENTER_RE, 64'hFFFF800000000000);
		write_reg(REG_CENTER_IM, 64'h7FFFFFFFFFFF);
		write_reg(REG_VIEW_SIDE, 64'h7FFFFFFFFFFF);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(511, 512);
		drain();
		write_reg(REG_CENTER_RE, -milli_q(750));
		write_reg(REG_CENTER_IM, milli_q(100));
		write_reg(REG_VIEW_SIDE, milli_q(20));
		send_pixel(512, 384);
		send_pixel(300, 600);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 56; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 56; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			if (ph == 5) begin
				rnd = {$urandom, $urandom};
				write_reg(REG_CENTER_RE, rnd);
				rnd = {$urandom, $urandom};
				write_reg(REG_CENTER_IM, rnd);
				rnd = {$urandom, $urandom};
				write_reg(REG_VIEW_SIDE, rnd);
			end else begin
				write_reg(REG_CENTER_RE, milli_q($urandom_range(0, 3000)) - milli_q(2000));
				write_reg(REG_CENTER_IM, milli_q($urandom_range(0, 2400)) - milli_q(1200));
				write_reg(REG_VIEW_SIDE, milli_q($urandom_range(1, 4000)));
			end
			write_reg(REG_MAX_ITER, (ph == 6) ? 0 : $urandom_range(1, 64));
			if (ph == 0) begin
				idle_pct = 0;
				hold_trig = 1'b1;
			end
			for (int n = 0; n < 56; n++)
				send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
			drain();
		end

		idle_pct = 0;
		repeat (100)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[mandelbrot_escape_pixel_unit] OK");
		else
			$display("[mandelbrot_escape_pixel_unit] ERROR");
		$finish;
	end

endmodule
